// ===== src/ccs_pkg.sv =====
`timescale 1ns / 1ps

package ccs_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Scanner mode of the front end.
	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_SLASH      = 3'd1,
		MODE_LINE       = 3'd2,
		MODE_BLOCK      = 3'd3,
		MODE_BLOCK_STAR = 3'd4
	} mode_t;

	// What the back end has to emit for one queued entry.
	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,  // the character alone
		KIND_PAIR  = 2'd1,  // a held slash, then the character
		KIND_EMPTY = 2'd2   // an empty word that only closes the text
	} kind_t;

	typedef struct packed {
		logic [7:0] ch;
		kind_t      kind;
		logic       fin;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t data;
	} fifo_wr_t;

endpackage

// ===== src/ccs_front.sv =====
`timescale 1ns / 1ps

module ccs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_ch,
	input  logic              in_fin,
	input  logic              fifo_full,
	output ccs_pkg::fifo_wr_t wr
);

	ccs_pkg::mode_t mode_q;
	ccs_pkg::mode_t mode_next;
	logic           emit;
	ccs_pkg::kind_t kind;
	logic           accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	// Next-state logic of the scanner.
	always_comb begin
		mode_next = ccs_pkg::MODE_NORMAL;
		unique case (mode_q)
			ccs_pkg::MODE_SLASH: begin
				if (in_ch == ccs_pkg::CH_SLASH) begin
					mode_next = ccs_pkg::MODE_LINE;
				end else if (in_ch == ccs_pkg::CH_STAR) begin
					mode_next = ccs_pkg::MODE_BLOCK;
				end else begin
					mode_next = ccs_pkg::MODE_NORMAL;
				end
			end
			ccs_pkg::MODE_LINE: begin
				if (in_ch == ccs_pkg::CH_NL) begin
					mode_next = ccs_pkg::MODE_NORMAL;
				end else begin
					mode_next = ccs_pkg::MODE_LINE;
				end
			end
			ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLOCK_STAR: begin
				if (mode_q == ccs_pkg::MODE_BLOCK_STAR && in_ch == ccs_pkg::CH_SLASH) begin
					mode_next = ccs_pkg::MODE_NORMAL;
				end else if (in_ch == ccs_pkg::CH_STAR) begin
					mode_next = ccs_pkg::MODE_BLOCK_STAR;
				end else begin
					mode_next = ccs_pkg::MODE_BLOCK;
				end
			end
			default: begin
				if (in_ch == ccs_pkg::CH_SLASH && !in_fin) begin
					mode_next = ccs_pkg::MODE_SLASH;
				end else begin
					mode_next = ccs_pkg::MODE_NORMAL;
				end
			end
		endcase
		// The final character always leaves the scanner ready for a new text.
		if (in_fin) begin
			mode_next = ccs_pkg::MODE_NORMAL;
		end
	end

	// Output logic: what, if anything, this word queues for the back end.
	always_comb begin
		emit = 1'b0;
		kind = ccs_pkg::KIND_CHAR;
		unique case (mode_q)
			ccs_pkg::MODE_SLASH: begin
				if (in_ch != ccs_pkg::CH_SLASH && in_ch != ccs_pkg::CH_STAR) begin
					emit = 1'b1;
					kind = ccs_pkg::KIND_PAIR;
				end
			end
			ccs_pkg::MODE_LINE: begin
				emit = (in_ch == ccs_pkg::CH_NL);
			end
			ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLOCK_STAR: begin
				// An unclosed block comment gives up its final character.
				if (!(mode_q == ccs_pkg::MODE_BLOCK_STAR && in_ch == ccs_pkg::CH_SLASH)) begin
					emit = in_fin;
				end
			end
			default: begin
				emit = !(in_ch == ccs_pkg::CH_SLASH && !in_fin);
			end
		endcase
		if (in_fin && !emit) begin
			emit = 1'b1;
			kind = ccs_pkg::KIND_EMPTY;
		end
	end

	assign wr.push      = accept && emit;
	assign wr.data.ch   = in_ch;
	assign wr.data.kind = kind;
	assign wr.data.fin  = in_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ccs_pkg::MODE_NORMAL;
		end else if (accept) begin
			mode_q <= mode_next;
		end
	end

endmodule

// ===== src/ccs_fifo.sv =====
`timescale 1ns / 1ps

module ccs_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ccs_pkg::fifo_wr_t wr,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output ccs_pkg::entry_t   head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	ccs_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = wr.push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/ccs_back.sv =====
`timescale 1ns / 1ps

module ccs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  ccs_pkg::entry_t head,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	logic       valid_q;
	logic       phase_q;
	logic [7:0] data_q;
	logic [1:0] user_q;
	logic       last_q;
	logic       load;
	logic       is_pair;
	logic [7:0] nx_ch;
	logic       nx_empty;
	logic       nx_run_end;
	logic       nx_text_end;

	assign load    = head_valid && (!valid_q || m_tready);
	assign is_pair = (head.kind == ccs_pkg::KIND_PAIR);
	// A pair entry is drained over two words; everything else in one.
	assign pop     = load && (!is_pair || phase_q);

	always_comb begin
		nx_ch       = head.ch;
		nx_empty    = 1'b0;
		nx_run_end  = 1'b1;
		nx_text_end = head.fin;
		unique case (head.kind)
			ccs_pkg::KIND_PAIR: begin
				if (!phase_q) begin
					nx_ch       = ccs_pkg::CH_SLASH;
					nx_run_end  = 1'b0;
					nx_text_end = 1'b0;
				end
			end
			ccs_pkg::KIND_EMPTY: begin
				nx_ch       = '0;
				nx_empty    = 1'b1;
				nx_text_end = 1'b1;
			end
			default: begin
				nx_ch = head.ch;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nx_ch;
			user_q <= {nx_run_end, nx_empty};
			last_q <= nx_text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (!valid_q || m_tready) begin
				valid_q <= head_valid;
			end
			if (load) begin
				phase_q <= is_pair && !phase_q;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

// ===== src/c_comment_stripper.sv =====
`timescale 1ns / 1ps
// The first output word of an input word passes through the queue, then the output register.
// Throughput: one input word per cycle while the queue is not full, one output word per cycle
// while m_tready is high; a held slash and an ordinary character after it give two output words.
// The queue between the scanner and the output stage absorbs those bursts and output stalls.
// Reset: arst_n clears the scanner mode, the queue and the output stage asynchronously.
module c_comment_stripper #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // final_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_ch
	output logic [1:0] m_tuser,   // [0] empty_res, [1] run_end
	output logic       m_tlast    // text_end
);

	ccs_pkg::fifo_wr_t wr;
	ccs_pkg::entry_t   head;
	logic              full;
	logic              head_valid;
	logic              pop;

	ccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ch     (s_tdata),
		.in_fin    (s_tlast),
		.fifo_full (full),
		.wr        (wr)
	);

	ccs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ccs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== src/ccs_checker.sv =====
`timescale 1ns / 1ps

module ccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// The word that ends a text is always the last word of its input word.
	a_text_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("text end without run end");

	// An empty word only closes a text and carries a zero character.
	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
		else $error("empty word not closing the text");

	// Only the released slash of a pair can be a word that does not end its run,
	// and the word that follows it ends the run.
	a_pair_slash: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata == ccs_pkg::CH_SLASH && !m_tuser[0])
		else $error("non-final word is not a held slash");

	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser[1] |=> m_tvalid && m_tuser[1] && !m_tuser[0])
		else $error("held slash not followed by its character");

	// A stalled word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed under stall");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
